// ===== rtl/lsau_pkg.sv =====
// lsau_pkg: shared types, constants and helper functions of the LFSR scrambler
// used by lsau_csr, lsau_core and the top level; no other dependencies
`default_nettype none
package lsau_pkg;

   // sizes
   localparam int MAX_LENGTH  = 64;
   localparam int LEN_W       = 7;
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 48;
   localparam int STEP_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP   = 3'd5;

   // item operations
   localparam logic OP_STEP    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // reset values of the configuration registers
   localparam logic                  RST_MODE   = 1'b0;
   localparam logic [LEN_W-1:0]      RST_LENGTH = 7'd7;
   localparam logic [MAX_LENGTH-1:0] RST_TAPS   = 64'd32;
   localparam logic [MAX_LENGTH-1:0] RST_SEED   = 64'd127;
   localparam logic [COUNT_W-1:0]    RST_PERIOD = 48'd1024;
   localparam logic [STEP_W-1:0]     RST_STEP   = 8'd1;

   typedef struct packed {
      logic                  mode_multiplicative;
      logic [LEN_W-1:0]      register_length;
      logic [MAX_LENGTH-1:0] tap_mask;
      logic [MAX_LENGTH-1:0] seed_value;
      logic [COUNT_W-1:0]    period_length;
      logic [STEP_W-1:0]     word_step;
   } cfg_type;

   // clamp the length to 2..MAX_LENGTH
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      if (len < LEN_W'(2)) begin
         res = LEN_W'(2);
      end else if (len > LEN_W'(MAX_LENGTH)) begin
         res = LEN_W'(MAX_LENGTH);
      end else begin
         res = len;
      end
      return res;
   endfunction

   // ones in every cell below len
   function automatic logic [MAX_LENGTH-1:0] low_mask(input logic [LEN_W-1:0] len);
      logic [MAX_LENGTH-1:0] m;
      for (int i = 0; i < MAX_LENGTH; i++) begin
         m[i] = (LEN_W'(i) < len);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lsau_csr.sv =====
// lsau_csr: configuration register file of the LFSR scrambler
// depends on lsau_pkg for the register indexes, reset values and cfg_type
`default_nettype none
module lsau_csr
   import lsau_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // write decode, indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   cfg_in.mode_multiplicative = csr_data[0];
            CSR_LENGTH: cfg_in.register_length     = csr_data[LEN_W-1:0];
            CSR_TAPS:   cfg_in.tap_mask            = csr_data[MAX_LENGTH-1:0];
            CSR_SEED:   cfg_in.seed_value          = csr_data[MAX_LENGTH-1:0];
            CSR_PERIOD: cfg_in.period_length       = csr_data[COUNT_W-1:0];
            CSR_STEP:   cfg_in.word_step           = csr_data[STEP_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_multiplicative <= RST_MODE;
         cfg_ff.register_length     <= RST_LENGTH;
         cfg_ff.tap_mask            <= RST_TAPS;
         cfg_ff.seed_value          <= RST_SEED;
         cfg_ff.period_length       <= RST_PERIOD;
         cfg_ff.word_step           <= RST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lsau_core.sv =====
// lsau_core: shift cells, step counter and the combinational feedback logic
// depends on lsau_pkg for cfg_type, op codes and the mask helpers
`default_nettype none
module lsau_core
   import lsau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    fire,
   input  wire logic    op,
   input  wire logic    data_bit,
   output      logic    out_bit
);

   logic [MAX_LENGTH-1:0] cells_ff, cells_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [LEN_W-1:0]      len;
   logic [IDX_W-1:0]      top_idx;
   logic [MAX_LENGTH-1:0] len_mask;
   logic [MAX_LENGTH-1:0] below_mask;
   logic                  top;
   logic                  fb;
   logic [COUNT_W:0]      cnt_sum;
   logic                  wrap;

   // effective length and masks
   assign len        = clamp_len(cfg.register_length);
   assign top_idx    = IDX_W'(len - LEN_W'(1));
   assign len_mask   = low_mask(len);
   assign below_mask = low_mask(LEN_W'(len - LEN_W'(1)));

   // feedback: top cell xor parity of tapped cells, data mixed in when multiplicative
   assign top = cells_ff[top_idx];
   assign fb  = top ^ (^(cells_ff & cfg.tap_mask & below_mask))
                ^ (cfg.mode_multiplicative & data_bit);
   assign out_bit = cfg.mode_multiplicative ? fb : top;

   // step counter, compared before truncation
   assign cnt_sum = {1'b0, count_ff} + (COUNT_W+1)'(cfg.word_step);
   assign wrap    = (cnt_sum >= {1'b0, cfg.period_length});

   // next state
   always_comb begin
      cells_in = cells_ff;
      count_in = count_ff;
      if (fire) begin
         if (op == OP_RESTART || wrap) begin
            cells_in = cfg.seed_value & len_mask;
            count_in = '0;
         end else begin
            cells_in = {cells_ff[MAX_LENGTH-2:0], fb} & len_mask;
            count_in = cnt_sum[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= RST_SEED & low_mask(clamp_len(RST_LENGTH));
         count_ff <= '0;
      end else begin
         cells_ff <= cells_in;
         count_ff <= count_in;
      end
   end

   // a restart always leaves a zero count
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && op == OP_RESTART) |=> (count_ff == '0))
      else $error("count not cleared after restart");

endmodule
`default_nettype wire

// ===== rtl/lfsr_scrambler_additive_multiplicative_unit.sv =====
// An item is held in the input register; when it fires, its bit goes into the result register.
// Throughput: one item per cycle while the result register is not stalled by rsp_ready.
// A restart item gives no result; the feedback xor and 48-bit count compare are combinational.
// Reset (synchronous, high): config registers to defaults, cells to masked seed, count to zero.
// Configuration writes are taken in any cycle, ready is always high.
// top level: handshake stages around lsau_core, with lsau_csr; depends on lsau_pkg
`default_nettype none
module lfsr_scrambler_additive_multiplicative_unit
   import lsau_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_op,
   input  wire logic                   req_data_bit,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_out_bit,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;

   logic in_valid_ff, in_valid_in;
   logic in_op_ff, in_data_ff;
   logic out_valid_ff, out_valid_in;
   logic out_bit_ff;
   logic core_bit;
   logic fire;

   lsau_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // the held item moves on when the result register is free or being drained
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   lsau_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (fire),
      .op       (in_op_ff),
      .data_bit (in_data_ff),
      .out_bit  (core_bit)
   );

   // input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // result register control
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && in_op_ff == OP_STEP) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_data_ff <= req_data_bit;
      end
      if (fire && in_op_ff == OP_STEP) begin
         out_bit_ff <= core_bit;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_out_bit = out_bit_ff;

   // a result shows up only after a step item went through the core
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire && in_op_ff == OP_STEP))
      else $error("result without a step item");

   // a restart item never creates a result
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && in_op_ff == OP_RESTART && rsp_ready) |=> !out_valid_ff)
      else $error("restart item produced a result");

   // a waiting result is never overwritten while it is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !fire)
      else $error("stalled result would be overwritten");

endmodule
`default_nettype wire
